@@ sv/pcm_pkg.sv @@
// ----------------------------------------------------------------------------
// pcm_pkg: shared definitions for the pointwise convolution MAC
// Channel counts, command and register codes, arithmetic widths and the
// weight write bundle.
// ----------------------------------------------------------------------------
package pcm_pkg;

   localparam int MAX_IN_CH  = 16;
   localparam int MAX_OUT_CH = 16;
   localparam int CH_W       = 4;     // width of channel index fields
   localparam int VAL_W      = 16;
   localparam int PROD_W     = 2 * VAL_W;
   localparam int ACC_W      = 40;
   localparam int FRAC_SHIFT = 12;    // Q.20 sum down to Q8.8

   // command codes, carried on req_tuser
   localparam logic [1:0] CMD_WEIGHT  = 2'd0;
   localparam logic [1:0] CMD_BIAS    = 2'd1;
   localparam logic [1:0] CMD_FEATURE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_IN_CH  = 2'd0;
   localparam logic [1:0] CSR_OUT_CH = 2'd1;
   localparam logic [1:0] CSR_PPF    = 2'd2;

   typedef struct packed {
      logic                    we;
      logic [CH_W-1:0]         out_idx;
      logic [CH_W-1:0]         in_idx;
      logic signed [VAL_W-1:0] data;
   } wt_wr_type;

endpackage

@@ sv/pcm_weight_bank.sv @@
// ----------------------------------------------------------------------------
// pcm_weight_bank: weight matrix and parallel multipliers
// Holds the weight matrix, one row per output channel, and multiplies the
// incoming feature by the weight column of its input channel in every lane.
// ----------------------------------------------------------------------------
module pcm_weight_bank
   import pcm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  wt_wr_type                wr,
   input  logic [CH_W-1:0]          rd_in,
   input  logic signed [VAL_W-1:0]  feature,
   output logic signed [PROD_W-1:0] prod_out [MAX_OUT_CH]
);

   logic signed [VAL_W-1:0]  wt_ff   [MAX_OUT_CH][MAX_IN_CH];
   logic signed [PROD_W-1:0] prod_ff [MAX_OUT_CH];
   logic signed [PROD_W-1:0] prod_in [MAX_OUT_CH];

   always_comb begin
      for (int o = 0; o < MAX_OUT_CH; o++) begin
         prod_in[o] = feature * wt_ff[o][rd_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int o = 0; o < MAX_OUT_CH; o++) begin
            for (int i = 0; i < MAX_IN_CH; i++) begin
               wt_ff[o][i] <= '0;
            end
         end
      end else if (wr.we) begin
         wt_ff[wr.out_idx][wr.in_idx] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_out = prod_ff;

endmodule

@@ sv/pointwise_conv_mac.sv @@
// ----------------------------------------------------------------------------
// pointwise_conv_mac: 1x1 convolution forward pass, Q8.8 in and out
// Weight, bias and feature transfers on one stream; one result per active
// output channel when the last active input channel of a position arrives.
// ----------------------------------------------------------------------------
// Input transfers are accepted one per cycle while req_tready is high and go
// through a register stage, a stage of sixteen parallel 16x16 multipliers and
// a stage of 40-bit accumulators. A feature of the last active input channel
// copies the sums into a result buffer, from which one result per cycle goes
// to the output register unless rsp_tready holds it. The buffer holds one
// position; the feature ending the next one waits in the accumulate stage
// until the buffer has drained. Results carry out_channel and activation on
// rsp_tdata, last_of_position on rsp_tlast and frame_end on rsp_tuser.
// Configuration must be written only while the block is idle (not enforced).
module pointwise_conv_mac
   import pcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // out_index[3:0], in_index[7:4], value[23:8]
   input  logic [1:0]  req_tuser,    // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // out_channel[3:0], activation[19:4], zero[23:20]
   output logic        rsp_tlast,    // last_of_position
   output logic [0:0]  rsp_tuser,    // frame_end[0]
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [16:0] csr_wdata
);

   // configuration
   logic [4:0]  in_ch_ff;
   logic [4:0]  out_ch_ff;
   logic [16:0] ppf_ff;
   logic [CH_W-1:0] in_last;
   logic [CH_W-1:0] out_last;
   logic [15:0]     ppf_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ch_ff  <= 5'd16;
         out_ch_ff <= 5'd16;
         ppf_ff    <= 17'd1024;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_IN_CH:  in_ch_ff  <= csr_wdata[4:0];
            CSR_OUT_CH: out_ch_ff <= csr_wdata[4:0];
            CSR_PPF:    ppf_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped counts, kept as "last index"
   always_comb begin
      if (in_ch_ff == '0)
         in_last = '0;
      else if (in_ch_ff > 5'(MAX_IN_CH))
         in_last = CH_W'(MAX_IN_CH - 1);
      else
         in_last = CH_W'(in_ch_ff - 5'd1);

      if (out_ch_ff == '0)
         out_last = '0;
      else if (out_ch_ff > 5'(MAX_OUT_CH))
         out_last = CH_W'(MAX_OUT_CH - 1);
      else
         out_last = CH_W'(out_ch_ff - 5'd1);

      if (ppf_ff == '0)
         ppf_last = '0;
      else if (ppf_ff > 17'd65536)
         ppf_last = 16'hFFFF;
      else
         ppf_last = 16'(ppf_ff - 17'd1);
   end

   // stage 1: input register
   logic                    s1_valid_ff;
   logic [1:0]              s1_cmd_ff;
   logic [CH_W-1:0]         s1_oi_ff;
   logic [CH_W-1:0]         s1_ii_ff;
   logic signed [VAL_W-1:0] s1_val_ff;
   logic                    s1_advance;
   logic                    s1_feat;

   // stage 2: accumulate
   logic                    s2_valid_ff;
   logic                    s2_emit_ff;
   logic                    s2_advance;
   logic                    s2_fire;
   logic signed [PROD_W-1:0] prod [MAX_OUT_CH];
   logic [ACC_W-1:0]        acc_ff  [MAX_OUT_CH];
   logic [ACC_W-1:0]        acc_sum [MAX_OUT_CH];
   logic                    acc_zero;
   logic [15:0]             pos_ff;
   logic                    frame_done;

   logic signed [VAL_W-1:0] bias_ff [MAX_OUT_CH];

   // result buffer and output register
   logic                    buf_busy_ff;
   logic [CH_W-1:0]         buf_last_ff;
   logic                    buf_fend_ff;
   logic [ACC_W-1:0]        buf_acc_ff  [MAX_OUT_CH];
   logic signed [VAL_W-1:0] buf_bias_ff [MAX_OUT_CH];
   logic [CH_W-1:0]         drain_ff;
   logic                    buf_load;
   logic                    out_load;
   logic signed [ACC_W:0]   round_sum;
   logic signed [VAL_W-1:0] sat_val;

   logic                    rsp_valid_ff;
   logic [CH_W-1:0]         rsp_chan_ff;
   logic signed [VAL_W-1:0] rsp_act_ff;
   logic                    rsp_last_ff;
   logic                    rsp_fend_ff;

   wt_wr_type               wt_wr;

   assign s2_advance = !(s2_valid_ff && s2_emit_ff && buf_busy_ff);
   assign s1_advance = !s2_valid_ff || s2_advance;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign s2_fire    = s2_valid_ff && s2_advance;
   assign buf_load   = s2_fire && s2_emit_ff;
   assign s1_feat    = s1_valid_ff && (s1_cmd_ff == CMD_FEATURE) && (s1_ii_ff <= in_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_cmd_ff <= req_tuser;
         s1_oi_ff  <= req_tdata[3:0];
         s1_ii_ff  <= req_tdata[7:4];
         s1_val_ff <= req_tdata[23:8];
      end
   end

   always_comb begin
      wt_wr.we      = s1_valid_ff && s1_advance && (s1_cmd_ff == CMD_WEIGHT);
      wt_wr.out_idx = s1_oi_ff;
      wt_wr.in_idx  = s1_ii_ff;
      wt_wr.data    = s1_val_ff;
   end

   pcm_weight_bank u_bank (
      .clock    (clock),
      .reset    (reset),
      .advance  (s1_advance),
      .wr       (wt_wr),
      .rd_in    (s1_ii_ff),
      .feature  (s1_val_ff),
      .prod_out (prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int o = 0; o < MAX_OUT_CH; o++) begin
            bias_ff[o] <= '0;
         end
      end else if (s1_valid_ff && s1_advance && (s1_cmd_ff == CMD_BIAS)) begin
         bias_ff[s1_oi_ff] <= s1_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_emit_ff  <= 1'b0;
      end else if (s1_advance) begin
         s2_valid_ff <= s1_feat;
         s2_emit_ff  <= (s1_ii_ff == in_last);
      end
   end

   always_comb begin
      acc_zero = 1'b1;
      for (int o = 0; o < MAX_OUT_CH; o++) begin
         acc_sum[o] = acc_ff[o] + ACC_W'(prod[o]);
         if (acc_ff[o] != '0) acc_zero = 1'b0;
      end
   end

   assign frame_done = (pos_ff >= ppf_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int o = 0; o < MAX_OUT_CH; o++) begin
            acc_ff[o] <= '0;
         end
         pos_ff <= '0;
      end else if (s2_fire) begin
         for (int o = 0; o < MAX_OUT_CH; o++) begin
            acc_ff[o] <= s2_emit_ff ? '0 : acc_sum[o];
         end
         if (s2_emit_ff) begin
            pos_ff <= frame_done ? '0 : pos_ff + 16'd1;
         end
      end
   end

   // position snapshot: wrapped sums and the bias in force at this point
   always_ff @(posedge clock) begin
      if (buf_load) begin
         buf_acc_ff  <= acc_sum;
         buf_bias_ff <= bias_ff;
         buf_last_ff <= out_last;
         buf_fend_ff <= frame_done;
      end
   end

   assign out_load = buf_busy_ff && (!rsp_valid_ff || rsp_tready);

   // round half up to Q8.8, then saturate
   always_comb begin
      round_sum = $signed({buf_acc_ff[drain_ff][ACC_W-1], buf_acc_ff[drain_ff]})
                + $signed({{(ACC_W + 1 - VAL_W - FRAC_SHIFT){buf_bias_ff[drain_ff][VAL_W-1]}},
                           buf_bias_ff[drain_ff], {FRAC_SHIFT{1'b0}}})
                + $signed((ACC_W + 1)'(1 << (FRAC_SHIFT - 1)));
      if (!round_sum[ACC_W] && (round_sum[ACC_W-1:FRAC_SHIFT+VAL_W-1] != '0))
         sat_val = 16'sh7FFF;
      else if (round_sum[ACC_W] && (round_sum[ACC_W-1:FRAC_SHIFT+VAL_W-1] != '1))
         sat_val = 16'sh8000;
      else
         sat_val = round_sum[FRAC_SHIFT+VAL_W-1:FRAC_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_busy_ff  <= 1'b0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (buf_load) begin
            buf_busy_ff <= 1'b1;
         end else if (out_load && (drain_ff == buf_last_ff)) begin
            buf_busy_ff <= 1'b0;
         end
         if (out_load) begin
            drain_ff <= (drain_ff == buf_last_ff) ? '0 : drain_ff + 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_chan_ff <= drain_ff;
         rsp_act_ff  <= sat_val;
         rsp_last_ff <= (drain_ff == buf_last_ff);
         rsp_fend_ff <= (drain_ff == buf_last_ff) && buf_fend_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_act_ff, rsp_chan_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_fend_ff;

   // a new position snapshot never overwrites one still draining
   a_buf_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      buf_load |-> !buf_busy_ff)
      else $error("result buffer loaded while busy");

   // accumulators restart from zero after each position
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      buf_load |=> acc_zero)
      else $error("accumulators not cleared after emission");

   // frame end only on the last channel of a position
   a_fend_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fend_ff) |-> rsp_last_ff)
      else $error("frame end without last of position");

   // draining index stays within the active output channels
   a_drain_range: assert property (@(posedge clock) disable iff (reset)
      buf_busy_ff |-> (drain_ff <= buf_last_ff))
      else $error("drain index past last output channel");

endmodule
